[rtl/tie_pkg.sv]
// Shared types and constants for the trapped instruction executor.
// Holds the request and response word layouts, the decoded class codes
// and the opcode values. No dependencies.
package tie_pkg;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  reg_select;
      logic [31:0] reg_value;
      logic [7:0]  opcode;
      logic [7:0]  next_byte;
      logic [31:0] response_data;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [20:0] address;
      logic [31:0] data;
      logic [2:0]  size_bytes;
      logic        at_stop;
      logic        last;
   } rsp_word_type;

   typedef logic [4:0] cls_code_type;

   typedef struct packed {
      cls_code_type cls;
      req_word_type word;
   } front_entry_type;

   localparam int LIN_BITS  = 21;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   localparam cls_code_type CLS_WR_REG   = 5'd0;
   localparam cls_code_type CLS_RD_REG   = 5'd1;
   localparam cls_code_type CLS_RESP     = 5'd2;
   localparam cls_code_type CLS_IN_IMM   = 5'd3;
   localparam cls_code_type CLS_OUT_IMM  = 5'd4;
   localparam cls_code_type CLS_IN_DX_B  = 5'd5;
   localparam cls_code_type CLS_IN_DX_W  = 5'd6;
   localparam cls_code_type CLS_IN_DX_D  = 5'd7;
   localparam cls_code_type CLS_OUT_DX_B = 5'd8;
   localparam cls_code_type CLS_OUT_DX_W = 5'd9;
   localparam cls_code_type CLS_OUT_DX_D = 5'd10;
   localparam cls_code_type CLS_CLI      = 5'd11;
   localparam cls_code_type CLS_STI      = 5'd12;
   localparam cls_code_type CLS_LOCK     = 5'd13;
   localparam cls_code_type CLS_PUSHF    = 5'd14;
   localparam cls_code_type CLS_PUSHBP   = 5'd15;
   localparam cls_code_type CLS_POPF     = 5'd16;
   localparam cls_code_type CLS_POPBP    = 5'd17;
   localparam cls_code_type CLS_RETN     = 5'd18;
   localparam cls_code_type CLS_RETF     = 5'd19;
   localparam cls_code_type CLS_BAD      = 5'd20;

   localparam logic [7:0] OPC_IN_IMM   = 8'he4;
   localparam logic [7:0] OPC_OUT_IMM  = 8'he6;
   localparam logic [7:0] OPC_IN_DX_B  = 8'hec;
   localparam logic [7:0] OPC_IN_DX_W  = 8'hed;
   localparam logic [7:0] OPC_OUT_DX_B = 8'hee;
   localparam logic [7:0] OPC_OUT_DX_W = 8'hef;
   localparam logic [7:0] OPC_CLI      = 8'hfa;
   localparam logic [7:0] OPC_STI      = 8'hfb;
   localparam logic [7:0] OPC_LOCK     = 8'hf0;
   localparam logic [7:0] OPC_PUSHF    = 8'h9c;
   localparam logic [7:0] OPC_PUSHBP   = 8'h55;
   localparam logic [7:0] OPC_POPF     = 8'h9d;
   localparam logic [7:0] OPC_POPBP    = 8'h5d;
   localparam logic [7:0] OPC_RETN     = 8'hc3;
   localparam logic [7:0] OPC_RETF     = 8'hcb;
   localparam logic [7:0] OPC_OPSIZE   = 8'h66;

endpackage

[rtl/tie_front.sv]
// Front end: accepts request words, classifies them and queues them.
// Two-entry queue toward the back end. Depends on tie_pkg.
module tie_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  tie_pkg::req_word_type     req_data,
   output logic                      valid,
   output tie_pkg::front_entry_type  entry,
   input  logic                      take
);

   localparam logic [1:0] KIND_WR_REG = 2'd0;
   localparam logic [1:0] KIND_RD_REG = 2'd1;
   localparam logic [1:0] KIND_INSTR  = 2'd2;

   tie_pkg::front_entry_type ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;

   function automatic tie_pkg::cls_code_type classify(input tie_pkg::req_word_type w);
      tie_pkg::cls_code_type c;
      c = tie_pkg::CLS_BAD;
      case (w.kind)
         KIND_WR_REG: c = tie_pkg::CLS_WR_REG;
         KIND_RD_REG: c = tie_pkg::CLS_RD_REG;
         KIND_INSTR: begin
            case (w.opcode)
               tie_pkg::OPC_IN_IMM:   c = tie_pkg::CLS_IN_IMM;
               tie_pkg::OPC_OUT_IMM:  c = tie_pkg::CLS_OUT_IMM;
               tie_pkg::OPC_IN_DX_B:  c = tie_pkg::CLS_IN_DX_B;
               tie_pkg::OPC_IN_DX_W:  c = tie_pkg::CLS_IN_DX_W;
               tie_pkg::OPC_OUT_DX_B: c = tie_pkg::CLS_OUT_DX_B;
               tie_pkg::OPC_OUT_DX_W: c = tie_pkg::CLS_OUT_DX_W;
               tie_pkg::OPC_CLI:      c = tie_pkg::CLS_CLI;
               tie_pkg::OPC_STI:      c = tie_pkg::CLS_STI;
               tie_pkg::OPC_LOCK:     c = tie_pkg::CLS_LOCK;
               tie_pkg::OPC_PUSHF:    c = tie_pkg::CLS_PUSHF;
               tie_pkg::OPC_PUSHBP:   c = tie_pkg::CLS_PUSHBP;
               tie_pkg::OPC_POPF:     c = tie_pkg::CLS_POPF;
               tie_pkg::OPC_POPBP:    c = tie_pkg::CLS_POPBP;
               tie_pkg::OPC_RETN:     c = tie_pkg::CLS_RETN;
               tie_pkg::OPC_RETF:     c = tie_pkg::CLS_RETF;
               tie_pkg::OPC_OPSIZE: begin
                  if (w.next_byte == tie_pkg::OPC_IN_DX_W) begin
                     c = tie_pkg::CLS_IN_DX_D;
                  end else if (w.next_byte == tie_pkg::OPC_OUT_DX_W) begin
                     c = tie_pkg::CLS_OUT_DX_D;
                  end else begin
                     c = tie_pkg::CLS_BAD;
                  end
               end
               default: c = tie_pkg::CLS_BAD;
            endcase
         end
         default: c = tie_pkg::CLS_RESP;
      endcase
      return c;
   endfunction

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign entry   = ent_ff[rd_ptr_ff];
   assign push_ok = push && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ (take && valid);
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, take && valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         ent_ff[wr_ptr_ff] <= '{cls: classify(req_data), word: req_data};
      end
   end

endmodule

[rtl/tie_back.sv]
// Back end: register file, instruction execution and response handling.
// Produces up to two result words per item. Depends on tie_pkg.
module tie_back #(
   parameter int MEM_ADDR_BITS = 21
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [20:0]               csr_data,
   input  logic                      valid,
   input  tie_pkg::front_entry_type  entry,
   output logic                      take,
   input  logic                      room,
   output logic [1:0]                res_count,
   output tie_pkg::rsp_word_type     res0,
   output tie_pkg::rsp_word_type     res1
);

   localparam logic [20:0] LIN_MASK = (MEM_ADDR_BITS >= tie_pkg::LIN_BITS) ? '1 :
      21'((64'd1 << MEM_ADDR_BITS) - 64'd1);

   localparam logic [2:0] ACT_REG_DATA  = 3'd0;
   localparam logic [2:0] ACT_PORT_RD   = 3'd1;
   localparam logic [2:0] ACT_PORT_WR   = 3'd2;
   localparam logic [2:0] ACT_MEM_RD    = 3'd3;
   localparam logic [2:0] ACT_MEM_WR    = 3'd4;
   localparam logic [2:0] ACT_DONE      = 3'd5;
   localparam logic [2:0] ACT_UNHANDLED = 3'd6;

   localparam logic [3:0] PND_NONE    = 4'd0;
   localparam logic [3:0] PND_IN_B    = 4'd1;
   localparam logic [3:0] PND_IN_W    = 4'd2;
   localparam logic [3:0] PND_IN_D    = 4'd3;
   localparam logic [3:0] PND_POPF    = 4'd4;
   localparam logic [3:0] PND_POPBP   = 4'd5;
   localparam logic [3:0] PND_RETN    = 4'd6;
   localparam logic [3:0] PND_RETF_IP = 4'd7;
   localparam logic [3:0] PND_RETF_CS = 4'd8;

   localparam logic [2:0] REG_AX = 3'd0;
   localparam logic [2:0] REG_DX = 3'd1;
   localparam logic [2:0] REG_BP = 3'd2;
   localparam logic [2:0] REG_SP = 3'd3;
   localparam logic [2:0] REG_IP = 3'd4;
   localparam logic [2:0] REG_FL = 3'd5;
   localparam logic [2:0] REG_CS = 3'd6;
   localparam logic [2:0] REG_SS = 3'd7;

   localparam logic [31:0] IF_MASK = 32'h0000_0200;

   logic [31:0] ax_ff, ax_in, dx_ff, dx_in, bp_ff, bp_in, sp_ff, sp_in;
   logic [31:0] ip_ff, ip_in, fl_ff, fl_in;
   logic [15:0] cs_ff, cs_in, ss_ff, ss_in;
   logic [3:0]  pending_ff, pending_in;
   logic [20:0] stop_ff;

   tie_pkg::req_word_type w;
   tie_pkg::rsp_word_type done_word;
   logic [31:0] sp_up, sp_down, ip_p1, ip_p2, reg_rd, bad_info;
   logic [20:0] rd_lin, wr_lin, here_lin, done_addr, port_dx, port_imm;
   logic        want_done;

   function automatic logic [20:0] lin(input logic [15:0] seg, input logic [15:0] off);
      return ({1'b0, seg, 4'b0000} + {5'b00000, off}) & LIN_MASK;
   endfunction

   function automatic tie_pkg::rsp_word_type word_of(input logic [2:0] act,
         input logic [20:0] addr, input logic [31:0] dat, input logic [2:0] size,
         input logic last);
      tie_pkg::rsp_word_type r;
      r.action     = act;
      r.address    = addr;
      r.data       = dat;
      r.size_bytes = size;
      r.at_stop    = 1'b0;
      r.last       = last;
      return r;
   endfunction

   assign w    = entry.word;
   assign take = valid && room;

   always_comb begin
      ax_in = ax_ff;
      dx_in = dx_ff;
      bp_in = bp_ff;
      sp_in = sp_ff;
      ip_in = ip_ff;
      fl_in = fl_ff;
      cs_in = cs_ff;
      ss_in = ss_ff;
      pending_in = pending_ff;
      res0 = '0;
      res1 = '0;
      res_count = 2'd0;
      want_done = 1'b0;

      sp_up    = {sp_ff[31:16], sp_ff[15:0] + 16'd2};
      sp_down  = {sp_ff[31:16], sp_ff[15:0] - 16'd2};
      ip_p1    = {ip_ff[31:16], ip_ff[15:0] + 16'd1};
      ip_p2    = {ip_ff[31:16], ip_ff[15:0] + 16'd2};
      rd_lin   = lin(ss_ff, sp_ff[15:0]);
      wr_lin   = lin(ss_ff, sp_down[15:0]);
      here_lin = lin(cs_ff, ip_ff[15:0]);
      port_dx  = {5'b00000, dx_ff[15:0]};
      port_imm = {13'd0, w.next_byte};
      bad_info = (w.opcode == tie_pkg::OPC_OPSIZE) ?
                 {16'd0, w.next_byte, tie_pkg::OPC_OPSIZE} : {24'd0, w.opcode};

      case (w.reg_select)
         REG_AX:  reg_rd = ax_ff;
         REG_DX:  reg_rd = dx_ff;
         REG_BP:  reg_rd = bp_ff;
         REG_SP:  reg_rd = sp_ff;
         REG_IP:  reg_rd = ip_ff;
         REG_FL:  reg_rd = fl_ff;
         REG_CS:  reg_rd = {16'd0, cs_ff};
         REG_SS:  reg_rd = {16'd0, ss_ff};
         default: reg_rd = '0;
      endcase

      if (take) begin
         if ((entry.cls != tie_pkg::CLS_WR_REG) && (entry.cls != tie_pkg::CLS_RD_REG)) begin
            pending_in = PND_NONE;
         end
         case (entry.cls)
            tie_pkg::CLS_WR_REG: begin
               case (w.reg_select)
                  REG_AX:  ax_in = w.reg_value;
                  REG_DX:  dx_in = w.reg_value;
                  REG_BP:  bp_in = w.reg_value;
                  REG_SP:  sp_in = w.reg_value;
                  REG_IP:  ip_in = w.reg_value;
                  REG_FL:  fl_in = w.reg_value;
                  REG_CS:  cs_in = w.reg_value[15:0];
                  REG_SS:  ss_in = w.reg_value[15:0];
                  default: ;
               endcase
            end
            tie_pkg::CLS_RD_REG: begin
               res0 = word_of(ACT_REG_DATA, 21'(w.reg_select), reg_rd, 3'd4, 1'b1);
               res_count = 2'd1;
            end
            tie_pkg::CLS_RESP: begin
               want_done = 1'b1;
               case (pending_ff)
                  PND_IN_B:  ax_in = {ax_ff[31:8], w.response_data[7:0]};
                  PND_IN_W:  ax_in = {ax_ff[31:16], w.response_data[15:0]};
                  PND_IN_D:  ax_in = w.response_data;
                  PND_POPF:  fl_in = {fl_ff[31:16], w.response_data[15:0]};
                  PND_POPBP: bp_in = {bp_ff[31:16], w.response_data[15:0]};
                  PND_RETN:  ip_in = {ip_ff[31:16], w.response_data[15:0]};
                  PND_RETF_IP: begin
                     want_done  = 1'b0;
                     ip_in      = {ip_ff[31:16], w.response_data[15:0]};
                     sp_in      = sp_up;
                     pending_in = PND_RETF_CS;
                     res0       = word_of(ACT_MEM_RD, rd_lin, '0, 3'd2, 1'b1);
                     res_count  = 2'd1;
                  end
                  PND_RETF_CS: cs_in = w.response_data[15:0];
                  default: want_done = 1'b0;
               endcase
            end
            tie_pkg::CLS_IN_IMM, tie_pkg::CLS_IN_DX_B, tie_pkg::CLS_IN_DX_W,
            tie_pkg::CLS_IN_DX_D: begin
               res_count = 2'd1;
               if (entry.cls == tie_pkg::CLS_IN_IMM) begin
                  res0 = word_of(ACT_PORT_RD, port_imm, '0, 3'd1, 1'b1);
                  ip_in = ip_p2;
                  pending_in = PND_IN_B;
               end else if (entry.cls == tie_pkg::CLS_IN_DX_B) begin
                  res0 = word_of(ACT_PORT_RD, port_dx, '0, 3'd1, 1'b1);
                  ip_in = ip_p1;
                  pending_in = PND_IN_B;
               end else if (entry.cls == tie_pkg::CLS_IN_DX_W) begin
                  res0 = word_of(ACT_PORT_RD, port_dx, '0, 3'd2, 1'b1);
                  ip_in = ip_p1;
                  pending_in = PND_IN_W;
               end else begin
                  res0 = word_of(ACT_PORT_RD, port_dx, '0, 3'd4, 1'b1);
                  ip_in = ip_p2;
                  pending_in = PND_IN_D;
               end
            end
            tie_pkg::CLS_OUT_IMM: begin
               res0 = word_of(ACT_PORT_WR, port_imm, {24'd0, ax_ff[7:0]}, 3'd1, 1'b0);
               res_count = 2'd1;
               ip_in = ip_p2;
               want_done = 1'b1;
            end
            tie_pkg::CLS_OUT_DX_B: begin
               res0 = word_of(ACT_PORT_WR, port_dx, {24'd0, ax_ff[7:0]}, 3'd1, 1'b0);
               res_count = 2'd1;
               ip_in = ip_p1;
               want_done = 1'b1;
            end
            tie_pkg::CLS_OUT_DX_W: begin
               res0 = word_of(ACT_PORT_WR, port_dx, {16'd0, ax_ff[15:0]}, 3'd2, 1'b0);
               res_count = 2'd1;
               ip_in = ip_p1;
               want_done = 1'b1;
            end
            tie_pkg::CLS_OUT_DX_D: begin
               res0 = word_of(ACT_PORT_WR, port_dx, ax_ff, 3'd4, 1'b0);
               res_count = 2'd1;
               ip_in = ip_p2;
               want_done = 1'b1;
            end
            tie_pkg::CLS_CLI: begin
               fl_in = fl_ff & ~IF_MASK;
               ip_in = ip_p1;
               want_done = 1'b1;
            end
            tie_pkg::CLS_STI: begin
               fl_in = fl_ff | IF_MASK;
               ip_in = ip_p1;
               want_done = 1'b1;
            end
            tie_pkg::CLS_LOCK: begin
               ip_in = ip_p1;
               want_done = 1'b1;
            end
            tie_pkg::CLS_PUSHF, tie_pkg::CLS_PUSHBP: begin
               res0 = word_of(ACT_MEM_WR, wr_lin,
                              (entry.cls == tie_pkg::CLS_PUSHF) ? {16'd0, fl_ff[15:0]} :
                                                                  {16'd0, bp_ff[15:0]},
                              3'd2, 1'b0);
               res_count = 2'd1;
               sp_in = sp_down;
               ip_in = ip_p1;
               want_done = 1'b1;
            end
            tie_pkg::CLS_POPF, tie_pkg::CLS_POPBP, tie_pkg::CLS_RETN,
            tie_pkg::CLS_RETF: begin
               res0 = word_of(ACT_MEM_RD, rd_lin, '0, 3'd2, 1'b1);
               res_count = 2'd1;
               sp_in = sp_up;
               if (entry.cls == tie_pkg::CLS_POPF) begin
                  ip_in = ip_p1;
                  pending_in = PND_POPF;
               end else if (entry.cls == tie_pkg::CLS_POPBP) begin
                  ip_in = ip_p1;
                  pending_in = PND_POPBP;
               end else if (entry.cls == tie_pkg::CLS_RETN) begin
                  pending_in = PND_RETN;
               end else begin
                  pending_in = PND_RETF_IP;
               end
            end
            default: begin
               res0 = word_of(ACT_UNHANDLED, here_lin, bad_info, 3'd0, 1'b1);
               res_count = 2'd1;
            end
         endcase
      end

      done_addr = lin(cs_in, ip_in[15:0]);
      done_word = word_of(ACT_DONE, done_addr, '0, 3'd0, 1'b1);
      done_word.at_stop = (done_addr == stop_ff);
      if (want_done) begin
         if (res_count == 2'd0) begin
            res0 = done_word;
         end else begin
            res1 = done_word;
         end
         res_count = res_count + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0;
         dx_ff <= '0;
         bp_ff <= '0;
         sp_ff <= '0;
         ip_ff <= '0;
         fl_ff <= '0;
         cs_ff <= '0;
         ss_ff <= '0;
         pending_ff <= PND_NONE;
         stop_ff <= '0;
      end else begin
         ax_ff <= ax_in;
         dx_ff <= dx_in;
         bp_ff <= bp_in;
         sp_ff <= sp_in;
         ip_ff <= ip_in;
         fl_ff <= fl_in;
         cs_ff <= cs_in;
         ss_ff <= ss_in;
         pending_ff <= pending_in;
         if (csr_valid) begin
            stop_ff <= csr_data;
         end
      end
   end

   a_two_results_order: assert property (@(posedge clock) disable iff (reset)
      take && (res_count == 2'd2) |-> !res0.last && res1.last)
      else $error("two-word item must end on its second word");

   a_stop_only_on_done: assert property (@(posedge clock) disable iff (reset)
      take && (res0.at_stop || res1.at_stop) |->
      ((res0.at_stop == 1'b0) || (res0.action == ACT_DONE)) &&
      ((res1.at_stop == 1'b0) || (res1.action == ACT_DONE)))
      else $error("at_stop set on a word that is not a done word");

   a_pending_holds: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(pending_ff))
      else $error("pending read changed without an item");

endmodule

[rtl/tie_rsp_queue.sv]
// Result queue between the back end and the result channel.
// Takes up to two words per cycle and delivers one per cycle while pop is high. Depends on tie_pkg.
module tie_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             wr_count,
   input  tie_pkg::rsp_word_type  wr0,
   input  tie_pkg::rsp_word_type  wr1,
   output logic                   room,
   output logic                   empty,
   input  logic                   pop,
   output tie_pkg::rsp_word_type  rsp_data
);

   tie_pkg::rsp_word_type mem_ff [tie_pkg::RSP_DEPTH];
   logic [tie_pkg::RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [tie_pkg::RSP_CNT_BITS-1:0] count_ff, count_in;
   logic pop_ok;

   assign empty    = (count_ff == '0);
   assign pop_ok   = pop && !empty;
   assign room     = (count_ff <= tie_pkg::RSP_CNT_BITS'(tie_pkg::RSP_DEPTH - 2));
   assign rsp_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + tie_pkg::RSP_PTR_BITS'(wr_count);
      rd_ptr_in = rd_ptr_ff + tie_pkg::RSP_PTR_BITS'(pop_ok);
      count_in  = count_ff + tie_pkg::RSP_CNT_BITS'(wr_count)
                  - tie_pkg::RSP_CNT_BITS'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr0;
      end
      if (wr_count == 2'd2) begin
         mem_ff[wr_ptr_ff + tie_pkg::RSP_PTR_BITS'(1)] <= wr1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tie_pkg::RSP_CNT_BITS'(tie_pkg::RSP_DEPTH))
      else $error("result queue overfilled");

   a_write_fits: assert property (@(posedge clock) disable iff (reset)
      (wr_count != 2'd0) |-> room)
      else $error("result words written without room");

endmodule

[rtl/v86_trapped_instruction_executor.sv]
// Usage notes:
// The request channel is a queue input: a word is taken at a clock edge with push
// high and full low. Each word is a register write, a register read, a trapped
// instruction or the data answering the last port or stack read.
// The result channel is a queue output: the oldest result word sits on rsp_data
// while empty is low and leaves at an edge with pop high.
// A request enters a two-word front queue, is executed by the back end at the head
// of that queue, and its result words are registered into the result queue.
// The back end executes one request per cycle as long as the four-word result
// queue has room for two words; requests that make two words drain at one word
// per cycle while pop is high, so the sustained rate is set by the single-word
// result port.
// When the receiver stalls, results collect in the result queue, then requests
// collect in the front queue, and full rises after that.
// The stop address is written through csr_valid/csr_data, always ready; the user
// must write it only while the block is idle, which the block does not enforce.
// Synchronous reset clears all registers, the stop address and any pending read,
// and empties both queues. Depends on tie_pkg, tie_front, tie_back, tie_rsp_queue.
module v86_trapped_instruction_executor #(
   parameter int MEM_ADDR_BITS = 21
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  tie_pkg::req_word_type  req_data,
   output logic                   empty,
   input  logic                   pop,
   output tie_pkg::rsp_word_type  rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [20:0]            csr_data
);

   tie_pkg::front_entry_type entry;
   tie_pkg::rsp_word_type    res0, res1;
   logic                     front_valid, take, room;
   logic [1:0]               res_count;

   assign csr_ready = 1'b1;

   tie_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .valid    (front_valid),
      .entry    (entry),
      .take     (take)
   );

   tie_back #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .valid     (front_valid),
      .entry     (entry),
      .take      (take),
      .room      (room),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   tie_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_count (res_count),
      .wr0      (res0),
      .wr1      (res1),
      .room     (room),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
